@@ src/mctg_pkg.sv @@
// Package for the motion command target gate: request types, register indexes and reset values.
package mctg_pkg;

    // Input request: a host command frame or a control tick.
    typedef struct packed {
        logic               cmd;
        logic [7:0]         ctrl_bits;
        logic signed [31:0] target_word;
        logic [7:0]         speed_req;
        logic               start_switch;
        logic               end_switch;
        logic signed [31:0] position_count;
        logic signed [31:0] step_capture;
        logic               home_armed;
        logic               link_ok;
        logic               over_current;
    } t_in_item;

    // Result request.
    typedef struct packed {
        logic signed [31:0] drive_target;
        logic [7:0]         speed_cmd;
        logic               drive_enable;
        logic               move_direction;
        logic               count_direction;
        logic [1:0]         limit_state;
        logic               clear_position;
        logic               report_request;
    } t_out_item;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_MAX_SPEED      = 3'd0,
        CFG_LIMIT_SPEED    = 3'd1,
        CFG_POSITION_LIMIT = 3'd2,
        CFG_ACCEPT_WINDOW  = 3'd3,
        CFG_HOLD_WINDOW    = 3'd4,
        CFG_HOME_FLOOR     = 3'd5
    } t_cfg_idx;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 31;

    // Request kinds.
    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Limit switch states.
    localparam logic [1:0] LIM_NONE  = 2'd0;
    localparam logic [1:0] LIM_START = 2'd1;
    localparam logic [1:0] LIM_END   = 2'd2;

    // Decoded control bit positions.
    localparam int unsigned DB_ENABLE = 0;
    localparam int unsigned DB_STOP   = 1;
    localparam int unsigned DB_MOVE   = 2;
    localparam int unsigned DB_COUNT  = 3;
    localparam int unsigned DB_REPORT = 4;

    // Register reset values.
    localparam logic [7:0]  RST_MAX_SPEED      = 8'd120;
    localparam logic [7:0]  RST_LIMIT_SPEED    = 8'd25;
    localparam logic [30:0] RST_POSITION_LIMIT = 31'd12000000;
    localparam logic [15:0] RST_ACCEPT_WINDOW  = 16'd20;
    localparam logic [15:0] RST_HOLD_WINDOW    = 16'd10;
    localparam logic [15:0] RST_HOME_FLOOR     = 16'd10;

endpackage

@@ src/motion_command_target_gate.sv @@
// Motion command target gate: stores host frames and on each tick works out the drive target.
//
// Usage: requests enter on the input channel (i_in_valid / o_in_ready, payload i_in).
// A frame request (cmd low) stores control bits, target and speed from the host. A tick
// request (cmd high) scans the limit switches, decodes the stored frame, clamps target and
// speed, gates acceptance of a new target on the settle window and picks the drive target.
// Every request yields exactly one result on the output channel (o_out_valid / i_out_ready,
// payload o_out); a frame result shows the held outputs with clear and report low.
// An accepted request is held in the input register, then its result in the result
// register; a receiver stall can hold the request in the input register in between.
// Throughput: one request per cycle while the receiver does not stall; the stored state
// sits next to the single pass of compare and clamp logic, so each request sees what
// the one before it left. When the receiver stalls, the result register holds and the
// input register takes one more request; o_in_ready then falls until the result is taken.
// Reset (i_rst_n low, synchronous) empties both stages, clears all stored state and loads
// the configuration reset values. Write configuration through i_cfg_we / i_cfg_idx /
// i_cfg_data only while no request is in flight; unknown indexes are ignored.
module motion_command_target_gate (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mctg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mctg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  mctg_pkg::t_in_item                 i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output mctg_pkg::t_out_item                o_out
);

    // Configuration registers.
    logic [7:0]  r_max_speed;
    logic [7:0]  r_limit_speed;
    logic [30:0] r_position_limit;
    logic [15:0] r_accept_window;
    logic [15:0] r_hold_window;
    logic [15:0] r_home_floor;

    // Pipeline registers.
    logic                 r_in_valid;
    mctg_pkg::t_in_item   r_in;
    logic                 r_out_valid;
    mctg_pkg::t_out_item  r_out;

    // Stored state.
    logic [7:0]         r_frame_ctrl;
    logic signed [31:0] r_frame_target;
    logic [7:0]         r_frame_speed;
    logic [4:0]         r_decoded;
    logic signed [31:0] r_aim_target;
    logic [7:0]         r_speed_value;
    logic signed [31:0] r_committed;
    logic signed [31:0] r_drive_target;
    logic [1:0]         r_limit;

    // Next values.
    logic [7:0]         n_frame_ctrl;
    logic signed [31:0] n_frame_target;
    logic [7:0]         n_frame_speed;
    logic [4:0]         n_decoded;
    logic signed [31:0] n_aim_target;
    logic [7:0]         n_speed_value;
    logic signed [31:0] n_committed;
    logic signed [31:0] n_drive_target;
    logic [1:0]         n_limit;
    mctg_pkg::t_out_item n_out;

    logic w_advance;
    logic w_fire;

    // The stage ahead advances when the result register is empty or being drained.
    assign w_advance   = !r_out_valid || i_out_ready;
    assign w_fire      = r_in_valid && w_advance;
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ---------------------------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed      <= mctg_pkg::RST_MAX_SPEED;
            r_limit_speed    <= mctg_pkg::RST_LIMIT_SPEED;
            r_position_limit <= mctg_pkg::RST_POSITION_LIMIT;
            r_accept_window  <= mctg_pkg::RST_ACCEPT_WINDOW;
            r_hold_window    <= mctg_pkg::RST_HOLD_WINDOW;
            r_home_floor     <= mctg_pkg::RST_HOME_FLOOR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mctg_pkg::CFG_MAX_SPEED:      r_max_speed      <= i_cfg_data[7:0];
                mctg_pkg::CFG_LIMIT_SPEED:    r_limit_speed    <= i_cfg_data[7:0];
                mctg_pkg::CFG_POSITION_LIMIT: r_position_limit <= i_cfg_data[30:0];
                mctg_pkg::CFG_ACCEPT_WINDOW:  r_accept_window  <= i_cfg_data[15:0];
                mctg_pkg::CFG_HOLD_WINDOW:    r_hold_window    <= i_cfg_data[15:0];
                mctg_pkg::CFG_HOME_FLOOR:     r_home_floor     <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------------------
    // Single pass: limit scan, frame decode, settle gate and drive target selection
    // ---------------------------------------------------------------------------------
    logic               w_start;
    logic               w_end;
    logic               w_clr;
    logic               w_pin;
    logic               w_rep;
    logic signed [32:0] w_pos33;
    logic signed [32:0] w_dt33;
    logic signed [31:0] w_pos1;
    logic signed [31:0] w_ftarget1;
    logic signed [31:0] w_committed1;
    logic signed [31:0] w_drive1;
    logic signed [32:0] w_aim33;
    logic signed [32:0] w_lim33;
    logic signed [32:0] w_floor33;
    logic signed [32:0] w_aim_clamp;
    logic [7:0]         w_spd;
    logic [4:0]         w_dec;
    logic signed [31:0] w_aim;
    logic [7:0]         w_speed;
    logic signed [33:0] w_cur34;
    logic signed [33:0] w_nxt34;
    logic signed [33:0] w_cap34;
    logic signed [33:0] w_aw34;
    logic signed [33:0] w_hw34;
    logic               w_take;
    logic signed [31:0] w_cur2;
    logic signed [33:0] w_cur2_34;
    logic               w_in_hold;
    logic signed [31:0] w_settled_drive;

    always_comb begin
        w_start = r_in.start_switch;
        w_end   = r_in.end_switch;
        w_pos33 = {r_in.position_count[31], r_in.position_count};
        w_dt33  = {r_drive_target[31], r_drive_target};

        // Limit scan: the start switch wins over the end switch.
        w_clr = w_start && (w_dt33 <= w_pos33) && r_in.home_armed;
        w_pin = !w_start && w_end && (w_dt33 >= w_pos33) && r_in.home_armed;
        if (w_start) begin
            n_limit = mctg_pkg::LIM_START;
        end else if (w_end) begin
            n_limit = mctg_pkg::LIM_END;
        end else begin
            n_limit = mctg_pkg::LIM_NONE;
        end

        // Homing zeroes everything, the end stop pins to the counter.
        if (w_clr) begin
            w_pos1       = '0;
            w_ftarget1   = '0;
            w_committed1 = '0;
            w_drive1     = '0;
        end else if (w_pin) begin
            w_pos1       = r_in.position_count;
            w_ftarget1   = r_in.position_count;
            w_committed1 = r_in.position_count;
            w_drive1     = r_in.position_count;
        end else begin
            w_pos1       = r_in.position_count;
            w_ftarget1   = r_frame_target;
            w_committed1 = r_committed;
            w_drive1     = r_drive_target;
        end

        // Frame decode: clamp target to the symmetric limit, then speed.
        w_aim33   = {w_ftarget1[31], w_ftarget1};
        w_lim33   = $signed({2'b00, r_position_limit});
        w_floor33 = $signed({17'd0, r_home_floor});
        if (w_aim33 > w_lim33) begin
            w_aim_clamp = w_lim33;
        end else if (w_aim33 < -w_lim33) begin
            w_aim_clamp = -w_lim33;
        end else begin
            w_aim_clamp = w_aim33;
        end
        w_spd = r_frame_speed;
        if (n_limit != mctg_pkg::LIM_NONE) begin
            w_spd = r_limit_speed;
            if ((n_limit == mctg_pkg::LIM_START) && (w_aim_clamp <= w_floor33)) begin
                w_aim_clamp = '0;
            end
        end else if (r_frame_speed > r_max_speed) begin
            w_spd = r_max_speed;
        end

        // Link down: hold the decoded bits, aim and speed.
        if (r_in.link_ok) begin
            w_dec   = {r_frame_ctrl[7], r_frame_ctrl[3:0]};
            w_aim   = w_aim_clamp[31:0];
            w_speed = w_spd;
        end else begin
            w_dec   = r_decoded;
            w_aim   = r_aim_target;
            w_speed = r_speed_value;
        end

        // Report: raise once, then drop the request bit.
        w_rep        = w_dec[mctg_pkg::DB_REPORT];
        n_frame_ctrl = r_frame_ctrl;
        if (w_rep) begin
            n_frame_ctrl[7]          = 1'b0;
            w_dec[mctg_pkg::DB_REPORT] = 1'b0;
        end

        // Settle gate: take the new aim once capture is near the committed target or, moving up, not above it.
        w_cur34 = {{2{w_committed1[31]}}, w_committed1};
        w_nxt34 = {{2{w_aim[31]}}, w_aim};
        w_cap34 = {{2{r_in.step_capture[31]}}, r_in.step_capture};
        w_aw34  = $signed({18'd0, r_accept_window});
        w_hw34  = $signed({18'd0, r_hold_window});
        if (w_cur34 == w_nxt34) begin
            w_take = 1'b0;
        end else if (w_nxt34 > w_cur34) begin
            w_take = (w_cur34 < w_cap34) ? ((w_cap34 - w_cur34) <= w_aw34) : 1'b1;
        end else begin
            w_take = (w_cur34 - w_cap34) <= w_aw34;
        end
        w_cur2    = w_take ? w_aim : w_committed1;
        w_cur2_34 = {{2{w_cur2[31]}}, w_cur2};
        w_in_hold = (w_cap34 > (w_cur2_34 - w_hw34)) && (w_cap34 < (w_cur2_34 + w_hw34));
        w_settled_drive = w_in_hold ? r_in.step_capture : w_cur2;

        // Default: hold all state.
        n_frame_target = r_frame_target;
        n_frame_speed  = r_frame_speed;
        n_decoded      = r_decoded;
        n_aim_target   = r_aim_target;
        n_speed_value  = r_speed_value;
        n_committed    = r_committed;
        n_drive_target = r_drive_target;
        n_out          = '0;

        if (r_in.cmd == mctg_pkg::CMD_FRAME) begin
            // Store the frame only.
            n_frame_ctrl   = r_in.ctrl_bits;
            n_frame_target = r_in.target_word;
            n_frame_speed  = r_in.speed_req;
            n_limit        = r_limit;
        end else begin
            n_frame_target = w_ftarget1;
            n_decoded      = w_dec;
            n_aim_target   = w_aim;
            n_speed_value  = w_speed;
            n_committed    = w_committed1;
            n_drive_target = w_drive1;
            if (w_dec[mctg_pkg::DB_ENABLE]) begin
                if (r_in.link_ok && !r_in.over_current && !w_dec[mctg_pkg::DB_STOP]) begin
                    n_committed    = w_cur2;
                    n_drive_target = w_settled_drive;
                end else begin
                    n_drive_target = w_pos1;
                end
            end
            n_out.clear_position = w_clr;
            n_out.report_request = w_rep;
        end

        n_out.drive_target    = n_drive_target;
        n_out.speed_cmd       = n_speed_value;
        n_out.drive_enable    = n_decoded[mctg_pkg::DB_ENABLE];
        n_out.move_direction  = n_decoded[mctg_pkg::DB_MOVE];
        n_out.count_direction = n_decoded[mctg_pkg::DB_COUNT];
        n_out.limit_state     = n_limit;
    end

    // ---------------------------------------------------------------------------------
    // Input register, stored state and result register
    // ---------------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_ctrl   <= '0;
            r_frame_target <= '0;
            r_frame_speed  <= '0;
            r_decoded      <= '0;
            r_aim_target   <= '0;
            r_speed_value  <= '0;
            r_committed    <= '0;
            r_drive_target <= '0;
            r_limit        <= mctg_pkg::LIM_NONE;
        end else if (w_fire) begin
            r_frame_ctrl   <= n_frame_ctrl;
            r_frame_target <= n_frame_target;
            r_frame_speed  <= n_frame_speed;
            r_decoded      <= n_decoded;
            r_aim_target   <= n_aim_target;
            r_speed_value  <= n_speed_value;
            r_committed    <= n_committed;
            r_drive_target <= n_drive_target;
            r_limit        <= n_limit;
        end
    end

    // ---------------------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------------------
    // Homing only happens at the start limit.
    a_clear_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.clear_position) |-> (o_out.limit_state == mctg_pkg::LIM_START))
        else $error("clear_position without start limit");

    // The input stage only blocks while the result register is stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !o_in_ready) |-> (r_out_valid && !i_out_ready))
        else $error("input stage blocked without output stall");

    // A fresh result always comes from a held input request.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without a request");

endmodule

@@ tb/sv/tb.sv @@
// Testbench for the motion command target gate: directed and random requests vs a predictor.
`timescale 1ns / 100ps

module tb;

    // Generous run limit in clock cycles.
    localparam int CYCLE_LIMIT = 200000;
    // Length of the long receiver hold-off that fills the block and stalls its input.
    localparam int LONG_STALL = 80;
    // Report request bit of the stored frame byte.
    localparam int unsigned FRAME_REPORT_BIT = 7;

    // Tick flag masks for push_tick: {start, end, armed, link, over-current}.
    localparam logic [4:0] TK_START = 5'b10000;
    localparam logic [4:0] TK_END   = 5'b01000;
    localparam logic [4:0] TK_ARMED = 5'b00100;
    localparam logic [4:0] TK_LINK  = 5'b00010;
    localparam logic [4:0] TK_OC    = 5'b00001;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [mctg_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [mctg_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                            i_in_valid;
    logic                            o_in_ready;
    mctg_pkg::t_in_item              i_in;
    logic                            o_out_valid;
    logic                            i_out_ready;
    mctg_pkg::t_out_item             o_out;

    motion_command_target_gate dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #6 i_clk = ~i_clk;

    // Requests waiting to be driven, and the results the predictor expects, oldest first.
    mctg_pkg::t_in_item  pending_requests[$];
    mctg_pkg::t_out_item expected_gate_results[$];

    int  error_count = 0;
    int  results_seen = 0;
    int  cycle_count = 0;
    int  sender_idle_pct;
    int  receiver_idle_pct;
    int  stall_requests = 0;
    int  stall_served = 0;
    int  stall_left = 0;
    logic in_taken = 1'b0;

    // Stimulus anchors: the last commanded target (clamped) and the one before it, so that
    // captures land near the committed target often enough to pass the settle window.
    longint anchor = 0;
    longint prev_anchor = 0;

    // Predictor copy of the configuration registers.
    logic [7:0]  cfg_max_speed      = mctg_pkg::RST_MAX_SPEED;
    logic [7:0]  cfg_limit_speed    = mctg_pkg::RST_LIMIT_SPEED;
    logic [30:0] cfg_position_limit = mctg_pkg::RST_POSITION_LIMIT;
    logic [15:0] cfg_accept_window  = mctg_pkg::RST_ACCEPT_WINDOW;
    logic [15:0] cfg_hold_window    = mctg_pkg::RST_HOLD_WINDOW;
    logic [15:0] cfg_home_floor     = mctg_pkg::RST_HOME_FLOOR;

    // Predictor copy of the stored state.
    logic [7:0]         frame_ctrl_q   = '0;
    logic signed [31:0] frame_target_q = '0;
    logic [7:0]         frame_speed_q  = '0;
    logic [4:0]         bits_q         = '0;
    logic signed [31:0] aim_q          = '0;
    logic [7:0]         speed_q        = '0;
    logic signed [31:0] committed_q    = '0;
    logic signed [31:0] drive_q        = '0;
    logic [1:0]         limit_q        = mctg_pkg::LIM_NONE;

    function automatic logic chance(int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    function automatic int jitter(int span);
        return int'($urandom_range(2 * span, 0)) - span;
    endfunction

    // Advance the predicted state by one request and return the result it yields.
    // Distances are worked out at 64 bits so that nothing wraps.
    function automatic mctg_pkg::t_out_item next_gate_result(mctg_pkg::t_in_item rq);
        mctg_pkg::t_out_item res;
        longint    pos, cap, drv, aim, lim, flr, cur, nxt, hw, aw;
        logic      clr, rep;
        clr = 1'b0;
        rep = 1'b0;
        if (rq.cmd == mctg_pkg::CMD_FRAME) begin
            frame_ctrl_q   = rq.ctrl_bits;
            frame_target_q = rq.target_word;
            frame_speed_q  = rq.speed_req;
        end else begin
            pos = rq.position_count;
            cap = rq.step_capture;
            drv = drive_q;
            // Scan the limits: the start switch wins over the end switch.
            if (rq.start_switch) begin
                limit_q = mctg_pkg::LIM_START;
                if (drv <= pos && rq.home_armed) begin
                    // Homing: zero target, drive target and counter.
                    frame_target_q = '0;
                    drive_q        = '0;
                    committed_q    = '0;
                    pos            = 0;
                    clr            = 1'b1;
                end
            end else if (rq.end_switch) begin
                limit_q = mctg_pkg::LIM_END;
                if (drv >= pos && rq.home_armed) begin
                    // End stop: pin the target to the counter.
                    frame_target_q = 32'(pos);
                    drive_q        = 32'(pos);
                    committed_q    = 32'(pos);
                end
            end else begin
                limit_q = mctg_pkg::LIM_NONE;
            end

            // Decode the stored frame only while the link is good; otherwise hold.
            if (rq.link_ok) begin
                bits_q = {frame_ctrl_q[FRAME_REPORT_BIT], frame_ctrl_q[3:0]};
                aim = frame_target_q;
                lim = cfg_position_limit;
                if (aim > lim) aim = lim;
                if (aim < -lim) aim = -lim;
                speed_q = frame_speed_q;
                if (limit_q == mctg_pkg::LIM_START || limit_q == mctg_pkg::LIM_END) begin
                    speed_q = cfg_limit_speed;
                    flr = cfg_home_floor;
                    if (limit_q == mctg_pkg::LIM_START && aim <= flr) aim = 0;
                end else if (frame_speed_q > cfg_max_speed) begin
                    speed_q = cfg_max_speed;
                end
                aim_q = 32'(aim);
            end

            // Raise the report once, then drop the request bit from frame and decode.
            if (bits_q[mctg_pkg::DB_REPORT]) begin
                rep = 1'b1;
                frame_ctrl_q[FRAME_REPORT_BIT] = 1'b0;
                bits_q[mctg_pkg::DB_REPORT] = 1'b0;
            end

            if (bits_q[mctg_pkg::DB_ENABLE]) begin
                if (rq.link_ok && !rq.over_current && !bits_q[mctg_pkg::DB_STOP]) begin
                    cur = committed_q;
                    nxt = aim_q;
                    hw  = cfg_hold_window;
                    aw  = cfg_accept_window;
                    // Take a new target once the capture is near the old one or, moving up, not above it.
                    if (cur != nxt) begin
                        if (nxt > cur) begin
                            if (cur < cap) begin
                                if (cap - cur <= aw) cur = nxt;
                            end else begin
                                cur = nxt;
                            end
                        end else if (cur - cap <= aw) begin
                            cur = nxt;
                        end
                    end
                    committed_q = 32'(cur);
                    // Hold the capture while it sits strictly inside the hold band.
                    if (cap > cur - hw && cap < cur + hw) drive_q = 32'(cap);
                    else drive_q = 32'(cur);
                end else begin
                    drive_q = 32'(pos);
                end
            end
        end
        res.drive_target    = drive_q;
        res.speed_cmd       = speed_q;
        res.drive_enable    = bits_q[mctg_pkg::DB_ENABLE];
        res.move_direction  = bits_q[mctg_pkg::DB_MOVE];
        res.count_direction = bits_q[mctg_pkg::DB_COUNT];
        res.limit_state     = limit_q;
        res.clear_position  = clr;
        res.report_request  = rep;
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] result %0d: %s", $time, results_seen, msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    task automatic push_frame(logic [7:0] ctrl, logic signed [31:0] tgt, logic [7:0] spd);
        mctg_pkg::t_in_item rq;
        rq = '0;
        rq.cmd         = mctg_pkg::CMD_FRAME;
        rq.ctrl_bits   = ctrl;
        rq.target_word = tgt;
        rq.speed_req   = spd;
        pending_requests.push_back(rq);
    endtask

    task automatic push_tick(logic [4:0] flags, logic signed [31:0] pos,
                             logic signed [31:0] cap);
        mctg_pkg::t_in_item rq;
        rq = '0;
        rq.cmd            = mctg_pkg::CMD_TICK;
        rq.start_switch   = |(flags & TK_START);
        rq.end_switch     = |(flags & TK_END);
        rq.home_armed     = |(flags & TK_ARMED);
        rq.link_ok        = |(flags & TK_LINK);
        rq.over_current   = |(flags & TK_OC);
        rq.position_count = pos;
        rq.step_capture   = cap;
        pending_requests.push_back(rq);
    endtask

    // Queue one frame followed by a run of ticks aimed around it, or now and then a fully
    // random request; n counts the requests queued.
    task automatic push_random_burst(inout int n);
        mctg_pkg::t_in_item rq;
        longint             tgt, lim;
        int                 k, ticks;
        logic [7:0]         ctrl;
        logic signed [31:0] cap, pos;
        if (chance(10)) begin
            rq.cmd            = 1'($urandom);
            rq.ctrl_bits      = 8'($urandom);
            rq.target_word    = $urandom;
            rq.speed_req      = 8'($urandom);
            rq.start_switch   = 1'($urandom);
            rq.end_switch     = 1'($urandom);
            rq.position_count = $urandom;
            rq.step_capture   = $urandom;
            rq.home_armed     = 1'($urandom);
            rq.link_ok        = 1'($urandom);
            rq.over_current   = 1'($urandom);
            pending_requests.push_back(rq);
            n++;
        end else begin
            lim = cfg_position_limit;
            k = $urandom_range(99, 0);
            if (k < 40) tgt = jitter(3000);
            else if (k < 60) tgt = (chance(50) ? lim : -lim) + jitter(3);
            else if (k < 75) tgt = int'($urandom);
            else tgt = anchor + jitter(100);
            ctrl = {chance(30), 3'($urandom), 1'($urandom), 1'($urandom), chance(10), chance(90)};
            push_frame(ctrl, 32'(tgt), 8'($urandom));
            prev_anchor = anchor;
            anchor = (tgt > lim) ? lim : ((tgt < -lim) ? -lim : tgt);
            ticks = $urandom_range(6, 1);
            repeat (ticks) begin
                k = $urandom_range(99, 0);
                if (k < 45) cap = 32'(anchor + jitter(40));
                else if (k < 70) cap = 32'(prev_anchor + jitter(40));
                else if (k < 80) cap = jitter(40);
                else cap = $urandom;
                k = $urandom_range(99, 0);
                if (k < 50) pos = 32'(longint'(cap) + jitter(30));
                else if (k < 70) pos = 32'(anchor + jitter(30));
                else pos = $urandom;
                push_tick({chance(8), chance(8), chance(75), chance(92), chance(5)}, pos, cap);
            end
            n += 1 + ticks;
        end
    endtask

    task automatic add_random(int count);
        int n;
        n = 0;
        while (n < count) push_random_burst(n);
    endtask

    // Write one register; the predictor copy takes the value masked to the register width.
    task automatic write_reg(mctg_pkg::t_cfg_idx idx, logic [mctg_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            mctg_pkg::CFG_MAX_SPEED:      cfg_max_speed      = val[7:0];
            mctg_pkg::CFG_LIMIT_SPEED:    cfg_limit_speed    = val[7:0];
            mctg_pkg::CFG_POSITION_LIMIT: cfg_position_limit = val[30:0];
            mctg_pkg::CFG_ACCEPT_WINDOW:  cfg_accept_window  = val[15:0];
            mctg_pkg::CFG_HOLD_WINDOW:    cfg_hold_window    = val[15:0];
            mctg_pkg::CFG_HOME_FLOOR:     cfg_home_floor     = val[15:0];
            default: ;
        endcase
    endtask

    task automatic load_config(logic [mctg_pkg::CFG_DATA_W-1:0] ms,
                               logic [mctg_pkg::CFG_DATA_W-1:0] ls,
                               logic [mctg_pkg::CFG_DATA_W-1:0] pl,
                               logic [mctg_pkg::CFG_DATA_W-1:0] aw,
                               logic [mctg_pkg::CFG_DATA_W-1:0] hw,
                               logic [mctg_pkg::CFG_DATA_W-1:0] hf);
        write_reg(mctg_pkg::CFG_MAX_SPEED, ms);
        write_reg(mctg_pkg::CFG_LIMIT_SPEED, ls);
        write_reg(mctg_pkg::CFG_POSITION_LIMIT, pl);
        write_reg(mctg_pkg::CFG_ACCEPT_WINDOW, aw);
        write_reg(mctg_pkg::CFG_HOLD_WINDOW, hw);
        write_reg(mctg_pkg::CFG_HOME_FLOOR, hf);
    endtask

    // Hold until every queued request has gone in and every expected result has come out.
    // Sample on the rising edge, where the driver's falling-edge updates have settled.
    task automatic wait_idle();
        while (pending_requests.size() != 0 || i_in_valid || expected_gate_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Request driver: offer the next request on the falling edge once the previous one
    // was taken, or idle for a cycle at the current sender rate.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (pending_requests.size() != 0 && !chance(sender_idle_pct)) begin
                i_in       <= pending_requests.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: stall at random, or hold ready low for a long stretch on request.
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (stall_served != stall_requests) begin
            stall_served <= stall_served + 1;
            stall_left   <= LONG_STALL;
            i_out_ready  <= 1'b0;
        end else begin
            i_out_ready <= !chance(receiver_idle_pct);
        end
    end

    // Monitor: check each result taken against the oldest expectation, then predict the
    // result of any request accepted on this edge.
    always @(posedge i_clk) begin : result_check
        mctg_pkg::t_out_item want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && o_in_ready;
            if (o_out_valid && i_out_ready) begin
                if (expected_gate_results.size() == 0) begin
                    report_mismatch("result arrived with none expected");
                end else begin
                    want = expected_gate_results.pop_front();
                    check_field("drive_target", o_out.drive_target, want.drive_target);
                    check_field("speed_cmd", 32'(o_out.speed_cmd), 32'(want.speed_cmd));
                    check_field("drive_enable", 32'(o_out.drive_enable),
                                32'(want.drive_enable));
                    check_field("move_direction", 32'(o_out.move_direction),
                                32'(want.move_direction));
                    check_field("count_direction", 32'(o_out.count_direction),
                                32'(want.count_direction));
                    check_field("limit_state", 32'(o_out.limit_state), 32'(want.limit_state));
                    check_field("clear_position", 32'(o_out.clear_position),
                                32'(want.clear_position));
                    check_field("report_request", 32'(o_out.report_request),
                                32'(want.report_request));
                end
                results_seen++;
            end
            if (i_in_valid && o_in_ready) expected_gate_results.push_back(next_gate_result(i_in));
        end
    end

    // Watchdog: drop the run if it hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_out_ready = 1'b0;
        sender_idle_pct   = 17;
        receiver_idle_pct = 54;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests on the reset configuration.
        push_tick('0, 0, 0);                                // link down, nothing stored
        push_frame(8'h8D, 100, 8'd200);                     // enable, both dirs, report
        push_tick(TK_LINK, 0, 0);                           // first target accepted
        push_tick(TK_LINK, 95, 95);                         // capture held inside the band
        push_tick(TK_LINK, 90, 90);                         // band edge is exclusive
        push_frame(8'h01, 32'h7FFF_FFFF, 8'hFF);            // highest target and speed
        push_tick(TK_LINK, 100, 200);                       // not yet settled
        push_tick(TK_LINK, 110, 120);                       // settled at exactly the window
        push_frame(8'h01, 32'h8000_0000, 8'h00);            // lowest target
        push_tick(TK_LINK, 0, 11999980);                    // downward accept at the window
        push_frame(8'h03, 500, 8'd120);                     // soft stop
        push_tick(TK_LINK, -777, 0);
        push_frame(8'h01, 500, 8'd50);
        push_tick(TK_LINK | TK_OC, -5, -12000000);          // over-current follows the counter
        push_tick(TK_ARMED, 1234, 0);                       // link down with enable held
        push_tick(TK_START | TK_ARMED | TK_LINK, 5000, 0);  // homing
        push_frame(8'h81, 7, 8'd99);
        push_tick(TK_START | TK_LINK, -100, 0);             // start limit, target under floor
        push_frame(8'h01, 5000, 8'd60);
        push_tick(TK_END | TK_ARMED | TK_LINK, -300, 0);    // end stop pins the target
        push_tick(TK_START | TK_END | TK_ARMED | TK_LINK, 100000, 0);
        push_tick(TK_END | TK_ARMED | TK_LINK, 32'h7FFF_FFFF, 0);
        push_frame(8'hF0, -42, 8'd7);                       // drive disabled, report set
        push_tick(TK_ARMED | TK_LINK, 3, 3);
        push_frame(8'hFF, 32'hFFFF_FFFF, 8'hFF);
        push_tick('1, 32'h8000_0000, 32'h7FFF_FFFF);
        add_random(250);
        wait_idle();

        // Widest clamps and accept window, zero hold window, no speed headroom; one long receiver hold-off.
        load_config(31'd0, 31'd255, 31'h7FFF_FFFF, 31'hFFFF, 31'd0, 31'hFFFF);
        add_random(250);
        stall_requests++;
        wait_idle();

        // Swap the idle rates; zero clamps, accept window and floor, widest hold window.
        sender_idle_pct   = 54;
        receiver_idle_pct = 17;
        load_config(31'd255, 31'd0, 31'd0, 31'd0, 31'hFFFF, 31'd0);
        add_random(250);
        wait_idle();

        // Small limits; the sender pauses halfway until every result is back.
        load_config(31'd60, 31'd7, 31'd1000, 31'd5, 31'd3, 31'd100);
        add_random(120);
        wait_idle();
        add_random(120);
        wait_idle();

        // No idling on either side; back to the reset values, with another hold-off.
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        load_config(31'(mctg_pkg::RST_MAX_SPEED), 31'(mctg_pkg::RST_LIMIT_SPEED),
                    31'(mctg_pkg::RST_POSITION_LIMIT), 31'(mctg_pkg::RST_ACCEPT_WINDOW),
                    31'(mctg_pkg::RST_HOLD_WINDOW), 31'(mctg_pkg::RST_HOME_FLOOR));
        add_random(200);
        stall_requests++;
        wait_idle();

        // Random settings; drive junk into the unused upper bits of the narrow registers.
        load_config(31'($urandom), 31'($urandom), 31'($urandom_range(50000, 0)),
                    {15'($urandom), 16'($urandom_range(200, 0))},
                    {15'($urandom), 16'($urandom_range(100, 0))},
                    {15'($urandom), 16'($urandom_range(3000, 0))});
        add_random(200);
        wait_idle();

        repeat (10) @(negedge i_clk);
        if (error_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/mctg_pkg.sv
src/motion_command_target_gate.sv
tb/sv/tb.sv
